// ===== rtl/fgu_pkg.sv =====
// Shared types and constants of the group FTRL weight update block.
// Used by the front, the back and the top module; depends on nothing.
package fgu_pkg;

  localparam int unsigned MaxGroup = 16;
  localparam int unsigned BufDepth = 32;
  localparam int unsigned BufAw    = $clog2(BufDepth);

  localparam logic [31:0] VMax = 32'h7fff_ffff;
  localparam logic [31:0] VMin = 32'h8000_0000;

  typedef enum logic [2:0] {
    RegAlphaInv  = 3'd0,
    RegBeta      = 3'd1,
    RegLambdaOne = 3'd2,
    RegLambdaTwo = 3'd3,
    RegGroupSize = 3'd4,
    RegGroupCnt  = 3'd5
  } reg_e;

  // Effective configuration (size and count already clamped).
  typedef struct packed {
    logic [30:0] alpha_inv;
    logic [30:0] beta;
    logic [30:0] lambda_one;
    logic [30:0] lambda_two;
    logic [4:0]  group_size;
    logic [15:0] group_count;
  } cfg_t;

  // One element buffered between front and back.
  typedef struct packed {
    logic [30:0] new_sq;
    logic [31:0] new_z;
  } elem_t;

  // One finished group.
  typedef struct packed {
    logic [63:0] norm;
    logic [4:0]  count;
    logic        last_m;
  } grp_t;

  typedef struct packed {
    logic [31:0] new_weight;
    logic [30:0] new_sq;
    logic [31:0] new_z;
    logic        last_g;
    logic        last_m;
  } res_t;

  // floor(sqrt(s) * 2^16) for the group sizes 1 to 16.
  function automatic logic [18:0] sqrt_size(logic [4:0] s);
    logic [18:0] r;
    unique case (s)
      5'd1:    r = 19'd65536;
      5'd2:    r = 19'd92681;
      5'd3:    r = 19'd113511;
      5'd4:    r = 19'd131072;
      5'd5:    r = 19'd146542;
      5'd6:    r = 19'd160529;
      5'd7:    r = 19'd173391;
      5'd8:    r = 19'd185363;
      5'd9:    r = 19'd196608;
      5'd10:   r = 19'd207243;
      5'd11:   r = 19'd217358;
      5'd12:   r = 19'd227023;
      5'd13:   r = 19'd236293;
      5'd14:   r = 19'd245213;
      5'd15:   r = 19'd253819;
      5'd16:   r = 19'd262144;
      default: r = 19'd65536;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/fgu_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module fgu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fgu_sqrt.sv =====
// Iterative integer square root of a 64-bit value, two radicand bits a cycle.
// Depends on nothing; used by the front and the back.
module fgu_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [35:0] sh, trial, diff;
  logic        ge;

  always_comb begin
    sh    = {rem_q, rad_q[63:62]};
    trial = {2'b00, root_q, 2'b01};
    diff  = sh - trial;
    ge    = (sh >= trial);
    rem_d  = ge ? diff[33:0] : sh[33:0];
    root_d = {root_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= (cnt_q != 5'd31);
      done_q <= (cnt_q == 5'd31);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
      cnt_q  <= cnt_q + 5'd1;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/fgu_front.sv =====
// Front part: takes one element, updates n and z, accumulates the group norm
// and hands elements and finished groups on. Depends on fgu_pkg and fgu_sqrt.
module fgu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [31:0]         weight_i,
  input  logic [30:0]         accum_sq_i,
  input  logic [31:0]         accum_z_i,
  input  logic [31:0]         gradient_i,
  input  fgu_pkg::cfg_t       cfg_i,
  input  logic                buf_full_i,
  input  logic                gq_full_i,
  output logic                elem_we_o,
  output fgu_pkg::elem_t      elem_o,
  output logic                gq_push_o,
  output fgu_pkg::grp_t       grp_o
);

  typedef enum logic [9:0] {
    F_IDLE = 10'b00_0000_0001,
    F_SQ   = 10'b00_0000_0010,
    F_NN   = 10'b00_0000_0100,
    F_S1   = 10'b00_0000_1000,
    F_S2   = 10'b00_0001_0000,
    F_SIG  = 10'b00_0010_0000,
    F_SW   = 10'b00_0100_0000,
    F_NZ   = 10'b00_1000_0000,
    F_AZ   = 10'b01_0000_0000,
    F_ACC  = 10'b10_0000_0000
  } fstate_e;

  fstate_e state_q, state_d;

  logic signed [31:0] w_q, z_q, g_q;
  logic [30:0]        n_q, nn_q, nn_d, sig_q;
  logic [63:0]        gg_q, az_q;
  logic [31:0]        sn_q, so_q;
  logic signed [63:0] sw_q;
  logic [31:0]        nz_q, nz_d;
  logic [63:0]        norm_q, norm_d;
  logic [3:0]         idx_q;
  logic [15:0]        gidx_q;

  logic        sq_start, sq_done;
  logic [63:0] sq_rad;
  logic [31:0] sq_root;

  logic [31:0]        ug, mag;
  logic [47:0]        nn_sum;
  logic [54:0]        sig_prod;
  logic signed [48:0] z_sum;
  logic [64:0]        norm_sum;
  logic               close, last_m, fire;

  fgu_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_rad),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  always_comb begin
    ug     = g_q[31] ? (~g_q + 32'd1) : g_q;
    nn_sum = {17'd0, n_q} + {1'b0, gg_q[62:16]};
    nn_d   = (nn_sum > 48'h7fff_ffff) ? 31'h7fff_ffff : nn_sum[30:0];
    sig_prod = (sn_q[23:0] - so_q[23:0]) * cfg_i.alpha_inv;
    // Flooring shift of sigma*w is the arithmetic shift of the product.
    z_sum = {{17{z_q[31]}}, z_q} + {{17{g_q[31]}}, g_q} - {sw_q[63], sw_q[63:16]};
    if (z_sum > $signed({17'd0, fgu_pkg::VMax})) begin
      nz_d = fgu_pkg::VMax;
    end else if (z_sum < $signed({{17{1'b1}}, fgu_pkg::VMin})) begin
      nz_d = fgu_pkg::VMin;
    end else begin
      nz_d = z_sum[31:0];
    end
    mag      = nz_q[31] ? (~nz_q + 32'd1) : nz_q;
    norm_sum = {1'b0, norm_q} + {1'b0, az_q};
    norm_d   = norm_sum[64] ? '1 : norm_sum[63:0];
    close    = ({1'b0, idx_q} + 5'd1) >= cfg_i.group_size;
    last_m   = ({1'b0, gidx_q} + 17'd1) >= {1'b0, cfg_i.group_count};
    fire     = (state_q == F_ACC) && !buf_full_i && !(close && gq_full_i);
  end

  always_comb begin
    state_d  = state_q;
    sq_start = 1'b0;
    sq_rad   = {17'd0, nn_d, 16'd0};
    unique case (state_q)
      F_IDLE: if (push_i) state_d = F_SQ;
      F_SQ:   state_d = F_NN;
      F_NN: begin
        sq_start = 1'b1;
        state_d  = F_S1;
      end
      F_S1: begin
        sq_rad = {17'd0, n_q, 16'd0};
        if (sq_done) begin
          sq_start = 1'b1;
          state_d  = F_S2;
        end
      end
      F_S2:  if (sq_done) state_d = F_SIG;
      F_SIG: state_d = F_SW;
      F_SW:  state_d = F_NZ;
      F_NZ:  state_d = F_AZ;
      F_AZ:  state_d = F_ACC;
      F_ACC: if (fire) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      norm_q  <= '0;
      idx_q   <= '0;
      gidx_q  <= '0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        if (close) begin
          norm_q <= '0;
          idx_q  <= '0;
          gidx_q <= last_m ? 16'd0 : gidx_q + 16'd1;
        end else begin
          norm_q <= norm_d;
          idx_q  <= idx_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i) begin
      w_q <= weight_i;
      n_q <= accum_sq_i;
      z_q <= accum_z_i;
      g_q <= gradient_i;
    end
    if (state_q == F_SQ) gg_q <= ug * ug;
    if (state_q == F_NN) nn_q <= nn_d;
    if (state_q == F_S1 && sq_done) sn_q <= sq_root;
    if (state_q == F_S2 && sq_done) so_q <= sq_root;
    if (state_q == F_SIG) begin
      sig_q <= (|sig_prod[54:47]) ? 31'h7fff_ffff : sig_prod[46:16];
    end
    if (state_q == F_SW) sw_q <= $signed({1'b0, sig_q}) * w_q;
    if (state_q == F_NZ) nz_q <= nz_d;
    if (state_q == F_AZ) az_q <= mag * mag;
  end

  assign full_o       = (state_q != F_IDLE);
  assign elem_we_o    = fire;
  assign elem_o       = '{new_sq: nn_q, new_z: nz_q};
  assign gq_push_o    = fire && close;
  assign grp_o.norm   = norm_d;
  assign grp_o.count  = {1'b0, idx_q} + 5'd1;
  assign grp_o.last_m = last_m;

endmodule

// ===== rtl/fgu_back.sv =====
// Back part: for each finished group takes the norm, the shrink factor and
// each element's new weight. Depends on fgu_pkg and fgu_sqrt.
module fgu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fgu_pkg::cfg_t  cfg_i,
  input  logic           gq_valid_i,
  input  fgu_pkg::grp_t  grp_i,
  output logic           gq_pop_o,
  output logic           buf_re_o,
  input  fgu_pkg::elem_t buf_rdata_i,
  input  logic           res_full_i,
  output logic           res_push_o,
  output fgu_pkg::res_t  res_o
);

  typedef enum logic [12:0] {
    B_IDLE  = 13'b0_0000_0000_0001,
    B_NORM  = 13'b0_0000_0000_0010,
    B_THR   = 13'b0_0000_0000_0100,
    B_FPREP = 13'b0_0000_0000_1000,
    B_FDIV  = 13'b0_0000_0001_0000,
    B_RD    = 13'b0_0000_0010_0000,
    B_RDW   = 13'b0_0000_0100_0000,
    B_SQ    = 13'b0_0000_1000_0000,
    B_NUM   = 13'b0_0001_0000_0000,
    B_DPREP = 13'b0_0010_0000_0000,
    B_DIV   = 13'b0_0100_0000_0000,
    B_OUT   = 13'b0_1000_0000_0000,
    B_SPARE = 13'b1_0000_0000_0000
  } bstate_e;

  bstate_e state_q, state_d;

  logic [3:0]         k_q;
  logic [31:0]        zn_q;
  logic [33:0]        thr_q;
  logic               prune_q, neg_q, zero_q;
  logic signed [16:0] factor_q;
  fgu_pkg::elem_t     elem_q;
  logic [62:0]        prod_q;
  logic signed [48:0] num_q;
  logic [47:0]        rem_q, dvd_q, den_q, quo_q;
  logic [5:0]         step_q;

  logic        sq_start, sq_done;
  logic [63:0] sq_rad;
  logic [31:0] sq_root;

  logic [48:0] sh, sub;
  logic        ge;
  logic [47:0] rem_n, quo_n;
  logic [48:0] num_mag;
  logic [49:0] thr_prod;
  logic [31:0] bs_sum;
  logic [31:0] nw;
  logic        last_e;

  fgu_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_rad),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  always_comb begin
    // One restoring division step, shared by the factor and the weight.
    sh       = {rem_q, dvd_q[47]};
    sub      = sh - {1'b0, den_q};
    ge       = (sh >= {1'b0, den_q});
    rem_n    = ge ? sub[47:0] : sh[47:0];
    quo_n    = {quo_q[46:0], ge};
    num_mag  = num_q[48] ? (~num_q + 49'd1) : num_q;
    thr_prod = cfg_i.lambda_one * fgu_pkg::sqrt_size(cfg_i.group_size);
    bs_sum   = {1'b0, cfg_i.beta} + sq_root;
    last_e   = ({1'b0, k_q} + 5'd1) == grp_i.count;
    if (zero_q) begin
      nw = '0;
    end else if (!neg_q) begin
      nw = (quo_q > {16'd0, fgu_pkg::VMax}) ? fgu_pkg::VMax : quo_q[31:0];
    end else begin
      nw = (quo_q > {16'd0, fgu_pkg::VMin}) ? fgu_pkg::VMin : (~quo_q[31:0] + 32'd1);
    end
  end

  always_comb begin
    state_d    = state_q;
    sq_start   = 1'b0;
    sq_rad     = grp_i.norm;
    buf_re_o   = 1'b0;
    res_push_o = 1'b0;
    gq_pop_o   = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (gq_valid_i) begin
          sq_start = 1'b1;
          state_d  = B_NORM;
        end
      end
      B_NORM:  if (sq_done) state_d = B_THR;
      B_THR:   state_d = B_FPREP;
      B_FPREP: state_d = ({2'b00, zn_q} > thr_q) ? B_FDIV : B_RD;
      B_FDIV:  if (step_q == 6'd0) state_d = B_RD;
      B_RD: begin
        buf_re_o = 1'b1;
        state_d  = B_RDW;
      end
      B_RDW: begin
        sq_rad   = {17'd0, buf_rdata_i.new_sq, 16'd0};
        sq_start = 1'b1;
        state_d  = B_SQ;
      end
      B_SQ:    if (sq_done) state_d = B_NUM;
      B_NUM:   state_d = B_DPREP;
      B_DPREP: state_d = (prune_q || den_q == '0) ? B_OUT : B_DIV;
      B_DIV:   if (step_q == 6'd0) state_d = B_OUT;
      B_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (last_e) begin
            gq_pop_o = 1'b1;
            state_d  = B_IDLE;
          end else begin
            state_d = B_RD;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: k_q <= '0;
      B_NORM: if (sq_done) zn_q <= sq_root;
      B_THR:  thr_q <= thr_prod[49:16];
      B_FPREP: begin
        prune_q  <= !({2'b00, zn_q} > thr_q);
        factor_q <= '0;
        rem_q    <= {16'd0, thr_q[31:0]};
        dvd_q    <= '0;
        den_q    <= {16'd0, zn_q};
        quo_q    <= '0;
        step_q   <= 6'd15;
      end
      B_FDIV: begin
        rem_q  <= rem_n;
        dvd_q  <= {dvd_q[46:0], 1'b0};
        quo_q  <= quo_n;
        step_q <= step_q - 6'd1;
        if (step_q == 6'd0) factor_q <= $signed({1'b0, quo_n[15:0]} - 17'h1_0000);
      end
      B_RD: ;
      B_RDW: elem_q <= buf_rdata_i;
      B_SQ:  if (sq_done) prod_q <= bs_sum * cfg_i.alpha_inv;
      B_NUM: begin
        den_q <= {1'b0, prod_q[62:16]} + {17'd0, cfg_i.lambda_two};
        num_q <= $signed(elem_q.new_z) * factor_q;
      end
      B_DPREP: begin
        neg_q  <= num_q[48];
        zero_q <= prune_q || den_q == '0;
        rem_q  <= '0;
        dvd_q  <= num_mag[47:0];
        quo_q  <= '0;
        step_q <= 6'd47;
      end
      B_DIV: begin
        rem_q  <= rem_n;
        dvd_q  <= {dvd_q[46:0], 1'b0};
        quo_q  <= quo_n;
        step_q <= step_q - 6'd1;
      end
      B_OUT: if (!res_full_i) k_q <= k_q + 4'd1;
      default: ;
    endcase
  end

  assign res_o.new_weight = nw;
  assign res_o.new_sq     = elem_q.new_sq;
  assign res_o.new_z      = elem_q.new_z;
  assign res_o.last_g     = last_e;
  assign res_o.last_m     = last_e && grp_i.last_m;

endmodule

// ===== rtl/group_ftrl_weight_update.sv =====
// Group-lasso FTRL-proximal weight update, signed Q16.16, saturating.
// Input queue side: an element (weight, n, z, gradient) is transferred when
// push is high and full is low. Result queue side: while empty is low the
// oldest result is on the result ports; it is transferred when pop is high.
// Configuration: cfg_valid_i/cfg_ready_o with a register index; ready is
// always high, and writes are meant for an idle block.
// The front takes one element at a time, raising full until it has handed it
// on, and its two square roots set its pace. Elements wait in a 32-entry
// buffer RAM; a finished group waits in a two-deep group queue. The back
// takes the group norm and factor (the factor division is skipped when the
// group is pruned), then for each element a square root and a division
// (skipped when pruned or the denominator is zero), so the back sets the
// sustained rate. No result of a group appears before its last element has
// been taken.
// Results collect in a two-entry output queue. When the receiver stalls the
// back waits, then the buffer fills and the front raises full.
// Reset clears the group position, the norm and all queues, and loads the
// register defaults. Buffered data needs no clearing.
module group_ftrl_weight_update (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] weight_i,
  input  logic [30:0] accum_sq_i,
  input  logic [31:0] accum_z_i,
  input  logic [31:0] gradient_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] new_weight_o,
  output logic [30:0] new_accum_sq_o,
  output logic [31:0] new_accum_z_o,
  output logic        last_of_group_o,
  output logic        last_of_matrix_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [30:0] alpha_q, beta_q, l1_q, l2_q;
  logic [4:0]  gs_q;
  logic [15:0] gc_q;
  fgu_pkg::cfg_t cfg;

  logic                  elem_we, buf_re, buf_full;
  fgu_pkg::elem_t        elem_w, elem_r;
  logic [fgu_pkg::BufAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [fgu_pkg::BufAw:0]   buf_cnt_q;

  logic          gq_push, gq_pop, gq_full, gq_valid;
  fgu_pkg::grp_t grp_w;
  fgu_pkg::grp_t gq_mem_q [2];
  logic          gq_wp_q, gq_rp_q;
  logic [1:0]    gq_cnt_q;

  logic          res_push, res_pop, res_full;
  fgu_pkg::res_t res_w, res_head;
  fgu_pkg::res_t rq_mem_q [2];
  logic          rq_wp_q, rq_rp_q;
  logic [1:0]    rq_cnt_q;

  // Registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 31'd65536;
      beta_q  <= 31'd65536;
      l1_q    <= '0;
      l2_q    <= '0;
      gs_q    <= 5'd16;
      gc_q    <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fgu_pkg::RegAlphaInv:  alpha_q <= cfg_data_i[30:0];
        fgu_pkg::RegBeta:      beta_q  <= cfg_data_i[30:0];
        fgu_pkg::RegLambdaOne: l1_q    <= cfg_data_i[30:0];
        fgu_pkg::RegLambdaTwo: l2_q    <= cfg_data_i[30:0];
        fgu_pkg::RegGroupSize: gs_q    <= cfg_data_i[4:0];
        fgu_pkg::RegGroupCnt:  gc_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg.alpha_inv  = alpha_q;
    cfg.beta       = beta_q;
    cfg.lambda_one = l1_q;
    cfg.lambda_two = l2_q;
    if (gs_q == 5'd0) begin
      cfg.group_size = 5'd1;
    end else if (gs_q > 5'(fgu_pkg::MaxGroup)) begin
      cfg.group_size = 5'(fgu_pkg::MaxGroup);
    end else begin
      cfg.group_size = gs_q;
    end
    cfg.group_count = (gc_q == 16'd0) ? 16'd1 : gc_q;
  end

  fgu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .weight_i   (weight_i),
    .accum_sq_i (accum_sq_i),
    .accum_z_i  (accum_z_i),
    .gradient_i (gradient_i),
    .cfg_i      (cfg),
    .buf_full_i (buf_full),
    .gq_full_i  (gq_full),
    .elem_we_o  (elem_we),
    .elem_o     (elem_w),
    .gq_push_o  (gq_push),
    .grp_o      (grp_w)
  );

  fgu_ram #(
    .Width ($bits(fgu_pkg::elem_t)),
    .Depth (fgu_pkg::BufDepth)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (elem_w),
    .re_i    (buf_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (elem_r)
  );

  assign buf_full = (buf_cnt_q == (fgu_pkg::BufAw+1)'(fgu_pkg::BufDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      buf_cnt_q <= '0;
    end else begin
      if (elem_we) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (buf_re)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (elem_we && !buf_re) begin
        buf_cnt_q <= buf_cnt_q + 1'b1;
      end else if (!elem_we && buf_re) begin
        buf_cnt_q <= buf_cnt_q - 1'b1;
      end
    end
  end

  // Group queue.
  assign gq_full  = (gq_cnt_q == 2'd2);
  assign gq_valid = (gq_cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gq_wp_q  <= 1'b0;
      gq_rp_q  <= 1'b0;
      gq_cnt_q <= '0;
    end else begin
      if (gq_push) gq_wp_q <= ~gq_wp_q;
      if (gq_pop)  gq_rp_q <= ~gq_rp_q;
      if (gq_push && !gq_pop) begin
        gq_cnt_q <= gq_cnt_q + 2'd1;
      end else if (!gq_push && gq_pop) begin
        gq_cnt_q <= gq_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (gq_push) gq_mem_q[gq_wp_q] <= grp_w;
  end

  fgu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .gq_valid_i  (gq_valid),
    .grp_i       (gq_mem_q[gq_rp_q]),
    .gq_pop_o    (gq_pop),
    .buf_re_o    (buf_re),
    .buf_rdata_i (elem_r),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_w)
  );

  // Result queue.
  assign res_full = (rq_cnt_q == 2'd2);
  assign empty    = (rq_cnt_q == 2'd0);
  assign res_pop  = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wp_q  <= 1'b0;
      rq_rp_q  <= 1'b0;
      rq_cnt_q <= '0;
    end else begin
      if (res_push) rq_wp_q <= ~rq_wp_q;
      if (res_pop)  rq_rp_q <= ~rq_rp_q;
      if (res_push && !res_pop) begin
        rq_cnt_q <= rq_cnt_q + 2'd1;
      end else if (!res_push && res_pop) begin
        rq_cnt_q <= rq_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) rq_mem_q[rq_wp_q] <= res_w;
  end

  assign res_head         = rq_mem_q[rq_rp_q];
  assign new_weight_o     = res_head.new_weight;
  assign new_accum_sq_o   = res_head.new_sq;
  assign new_accum_z_o    = res_head.new_z;
  assign last_of_group_o  = res_head.last_g;
  assign last_of_matrix_o = res_head.last_m;

endmodule

// ===== bench/tb.sv =====
// Testbench for group_ftrl_weight_update: checks every result against a cycle-free
// predictor of the group-lasso FTRL update. Depends on fgu_pkg and the block RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VMAXL = 64'sh7fff_ffff;
  localparam longint VMINL = -64'sh8000_0000;
  localparam int unsigned SETTLE = 400;

  typedef struct {
    logic [31:0] new_weight;
    logic [30:0] new_sq;
    logic [31:0] new_z;
    logic        last_g;
    logic        last_m;
  } update_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] weight_i = '0;
  logic [30:0] accum_sq_i = '0;
  logic [31:0] accum_z_i = '0;
  logic [31:0] gradient_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] new_weight_o;
  logic [30:0] new_accum_sq_o;
  logic [31:0] new_accum_z_o;
  logic        last_of_group_o;
  logic        last_of_matrix_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  group_ftrl_weight_update dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Predictor state: registers, per-group buffers and group position.
  longint unsigned m_alpha, m_beta, m_lam1, m_lam2, m_size, m_count;
  longint          buf_w[fgu_pkg::MaxGroup], buf_sq[fgu_pkg::MaxGroup];
  longint          buf_z[fgu_pkg::MaxGroup];
  longint unsigned norm_acc;
  int unsigned     elem_pos, group_pos;

  update_t pending_updates[$];
  int      fail_count = 0;
  int      idle_pct = 0, stall_pct = 0, hold_cycles = 0;

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp_s(longint v);
    if (v > VMAXL) return VMAXL;
    if (v < VMINL) return VMINL;
    return v;
  endfunction

  function automatic void model_write(logic [2:0] idx, logic [31:0] data);
    case (idx)
      fgu_pkg::RegAlphaInv:  m_alpha = data[30:0];
      fgu_pkg::RegBeta:      m_beta  = data[30:0];
      fgu_pkg::RegLambdaOne: m_lam1  = data[30:0];
      fgu_pkg::RegLambdaTwo: m_lam2  = data[30:0];
      fgu_pkg::RegGroupSize: m_size  = data[4:0];
      fgu_pkg::RegGroupCnt:  m_count = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic void update_element(logic [31:0] w_b, logic [30:0] n_b,
                                         logic [31:0] z_b, logic [31:0] g_b);
    longint          w, z, g, nz, factor, nw;
    longint unsigned n, ug, nn, sn, so, sig, az, sum, thr, zn, s, den;
    int unsigned     idx, gs, cnt, gc;
    bit              prune, last_m;
    update_t         u;
    w = longint'($signed(w_b));
    z = longint'($signed(z_b));
    g = longint'($signed(g_b));
    n = n_b;
    ug = (g < 0) ? longint'(-g) : longint'(g);
    nn = n + ((ug * ug) >> 16);
    if (nn > VMAXL) nn = VMAXL;
    sn = root64(nn << 16);
    so = root64(n << 16);
    sig = ((sn - so) * m_alpha) >> 16;
    if (sig > VMAXL) sig = VMAXL;
    nz = clamp_s(z + g - ((longint'(sig) * w) >>> 16));
    idx = elem_pos % fgu_pkg::MaxGroup;
    buf_w[idx] = w;
    buf_sq[idx] = longint'(nn);
    buf_z[idx] = nz;
    az = (nz < 0) ? longint'(-nz) : longint'(nz);
    az = az * az;
    sum = norm_acc + az;
    norm_acc = (sum < norm_acc) ? 64'hffff_ffff_ffff_ffff : sum;
    gs = (m_size == 0) ? 1 :
         (m_size > fgu_pkg::MaxGroup) ? fgu_pkg::MaxGroup : int'(m_size);
    if (idx + 1 < gs) begin
      elem_pos = idx + 1;
      return;
    end
    cnt = idx + 1;
    gc = (m_count == 0) ? 1 : int'(m_count);
    last_m = (group_pos + 1 >= gc);
    thr = (m_lam1 * root64(longint'(gs) << 32)) >> 16;
    zn = root64(norm_acc);
    prune = !(zn > thr);
    factor = prune ? 0 : longint'((thr << 16) / zn) - 65536;
    for (int k = 0; k < cnt; k++) begin
      s = root64(longint'(buf_sq[k]) << 16);
      den = (((m_beta + s) * m_alpha) >> 16) + m_lam2;
      nw = 0;
      if (!prune && den != 0) nw = clamp_s((buf_z[k] * factor) / longint'(den));
      u.new_weight = nw[31:0];
      u.new_sq = buf_sq[k][30:0];
      u.new_z = buf_z[k][31:0];
      u.last_g = (k + 1 == cnt);
      u.last_m = (k + 1 == cnt) && last_m;
      pending_updates.push_back(u);
    end
    norm_acc = 0;
    elem_pos = 0;
    group_pos = last_m ? 0 : ((group_pos + 1) & 16'hffff);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  // Result side: pop decided at the falling edge, transfer sampled at the rising edge.
  initial begin
    update_t u;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop = 1'b0;
      end else begin
        pop = ($urandom_range(99) >= stall_pct);
      end
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (pending_updates.size() == 0) begin
          report_mismatch("unexpected result", new_accum_z_o, 0);
        end else begin
          u = pending_updates.pop_front();
          if (new_weight_o !== u.new_weight)
            report_mismatch("new_weight", new_weight_o, u.new_weight);
          if (new_accum_sq_o !== u.new_sq)
            report_mismatch("new_accum_sq", new_accum_sq_o, u.new_sq);
          if (new_accum_z_o !== u.new_z)
            report_mismatch("new_accum_z", new_accum_z_o, u.new_z);
          if (last_of_group_o !== u.last_g)
            report_mismatch("last_of_group", last_of_group_o, u.last_g);
          if (last_of_matrix_o !== u.last_m)
            report_mismatch("last_of_matrix", last_of_matrix_o, u.last_m);
        end
      end
    end
  end

  // Called and left at a falling edge; push stays high between back-to-back items.
  task automatic send_element(logic [31:0] w, logic [30:0] n, logic [31:0] z,
                              logic [31:0] g);
    while ($urandom_range(99) < idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    weight_i = w;
    accum_sq_i = n;
    accum_z_i = z;
    gradient_i = g;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    update_element(w, n, z, g);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    push = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    model_write(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_quiet();
    push = 1'b0;
    while (pending_updates.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_signed();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4: return 32'($signed($urandom_range(2 * 65536 * 4)) - 65536 * 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_accum();
    case ($urandom_range(7))
      0: return 31'h7fff_ffff;
      1: return '0;
      2, 3: return 31'($urandom_range(65536 * 8));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count) send_element(pick_signed(), pick_accum(), pick_signed(), pick_signed());
  endtask

  task automatic test_defaults();
    // Reset values: groups of sixteen, no pruning threshold.
    for (int i = 0; i < 16; i++)
      send_element((i % 2) ? 32'h8000_0000 : 32'h7fff_ffff,
                   (i % 3 == 0) ? 31'h7fff_ffff : 31'(i * 4096),
                   (i % 2) ? 32'h7fff_ffff : 32'h8000_0000,
                   (i % 4 == 1) ? 32'h8000_0000 : 32'(i * 70000));
    wait_quiet();
  endtask

  task automatic test_zero_denominator();
    // beta zero and n, g zero give a zero denominator on an unpruned group.
    write_reg(fgu_pkg::RegBeta, 32'h0);
    write_reg(fgu_pkg::RegLambdaTwo, 32'h0);
    write_reg(fgu_pkg::RegLambdaOne, 32'h1);
    write_reg(fgu_pkg::RegGroupSize, 32'h2);
    write_reg(fgu_pkg::RegGroupCnt, 32'h2);
    send_element(32'h0001_0000, 31'h0, 32'h4000_0000, 32'h0);
    send_element(32'hffff_0000, 31'h0001_0000, 32'hc000_0000, 32'h0002_0000);
    send_element(32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_element(32'h8000_0000, 31'h0, 32'h8000_0000, 32'h8000_0000);
    wait_quiet();
  endtask

  task automatic test_clamps();
    // A size of zero acts as one, a count of zero as one; upper bits are dropped.
    write_reg(fgu_pkg::RegGroupSize, 32'h0000_0020);
    write_reg(fgu_pkg::RegGroupCnt, 32'h0001_0000);
    write_reg(3'd6, 32'h0000_0003);
    write_reg(3'd7, 32'hffff_ffff);
    write_reg(fgu_pkg::RegAlphaInv, 32'hffff_ffff);
    send_element(32'h0002_0000, 31'h0000_1000, 32'h0003_0000, 32'hfffe_0000);
    send_element(32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    wait_quiet();
  endtask

  task automatic test_shrink();
    // Size shrunk below the group position: the next item closes the group.
    write_reg(fgu_pkg::RegAlphaInv, 32'h0001_0000);
    write_reg(fgu_pkg::RegBeta, 32'h0001_0000);
    write_reg(fgu_pkg::RegGroupSize, 32'h6);
    write_reg(fgu_pkg::RegGroupCnt, 32'h3);
    send_random(3);
    wait_quiet();
    write_reg(fgu_pkg::RegGroupSize, 32'h2);
    send_random(1);
    wait_quiet();
    // Count shrunk below the group index: that group ends the matrix.
    send_random(2);
    wait_quiet();
    write_reg(fgu_pkg::RegGroupCnt, 32'h1);
    send_random(2);
    wait_quiet();
  endtask

  task automatic test_backpressure();
    // The receiver holds off while the sender fills the buffer and full rises.
    write_reg(fgu_pkg::RegGroupSize, 32'd17);
    write_reg(fgu_pkg::RegLambdaOne, 32'h0000_8000);
    idle_pct = 0;
    hold_cycles = 6000;
    send_random(48);
    wait_quiet();
  endtask

  task automatic run_phase(int phase, int send_idle, int recv_stall, int items);
    int sent, gs;
    case (phase)
      0: write_reg(fgu_pkg::RegAlphaInv, 32'h1);
      1: write_reg(fgu_pkg::RegAlphaInv, 32'h7fff_ffff);
      default: write_reg(fgu_pkg::RegAlphaInv, $urandom_range(32'h0004_0000, 1));
    endcase
    write_reg(fgu_pkg::RegBeta,
              (phase == 1) ? 32'h7fff_ffff : $urandom_range(32'h0004_0000));
    case (phase)
      0: write_reg(fgu_pkg::RegLambdaOne, 32'h0);
      1: write_reg(fgu_pkg::RegLambdaOne, 32'h7fff_ffff);
      default: write_reg(fgu_pkg::RegLambdaOne, $urandom_range(32'h0010_0000));
    endcase
    write_reg(fgu_pkg::RegLambdaTwo, (phase == 1) ? 32'h7fff_ffff :
              (phase == 0) ? 32'h0 : $urandom_range(32'h0004_0000));
    gs = (phase == 1) ? 16 : (phase == 0) ? 1 : $urandom_range(8, 2);
    write_reg(fgu_pkg::RegGroupSize, 32'(gs));
    write_reg(fgu_pkg::RegGroupCnt,
              (phase == 3) ? 32'hffff : 32'($urandom_range(4, 1)));
    idle_pct = send_idle;
    stall_pct = recv_stall;
    sent = 0;
    while (sent < items) begin
      send_random(gs);
      sent += gs;
    end
    wait_quiet();
  endtask

  initial begin
    m_alpha = 65536; m_beta = 65536; m_lam1 = 0; m_lam2 = 0;
    m_size = 16; m_count = 1;
    norm_acc = 0; elem_pos = 0; group_pos = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_defaults();
    test_zero_denominator();
    test_clamps();
    test_shrink();
    test_backpressure();
    run_phase(0, 0, 0, 56);
    run_phase(1, 65, 0, 56);
    run_phase(2, 0, 65, 56);
    run_phase(3, 35, 35, 56);
    if (fail_count == 0 && pending_updates.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
